### src/multichannel_trimmed_mean_filter_top_macros.svh
// assertion macros shared by the trimmed mean filter rtl
`ifndef MULTICHANNEL_TRIMMED_MEAN_FILTER_TOP_MACROS_SVH
`define MULTICHANNEL_TRIMMED_MEAN_FILTER_TOP_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clk, off during reset
`define MCTMF_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define MCTMF_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define MCTMF_ASSERT_NOW(name, ante, cons)
`define MCTMF_ASSERT_NEXT(name, ante, cons)

`endif

`endif

### src/mctmf_pkg.sv
// shared types and constants of the trimmed mean filter
package mctmf_pkg;

    // width of the channel field of an input transfer
    localparam int CHANNEL_W = 3;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_RANK,
        ST_LAST,
        ST_DIVGO,
        ST_DIV,
        ST_DONE
    } state_t;

    // status of the iterative divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### src/mctmf_in_if.sv
// input channel: channel number and sample with valid/ready
interface mctmf_in_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                             valid;
    logic                             ready;
    logic [mctmf_pkg::CHANNEL_W-1:0]  channel;
    logic signed [SAMPLE_WIDTH-1:0]   sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

### src/mctmf_out_if.sv
// output channel: filtered value and filled flag with valid/ready
interface mctmf_out_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] filtered;
    logic                           buffer_filled;

    modport source (output valid, output filtered, output buffer_filled, input ready);
    modport sink   (input valid, input filtered, input buffer_filled, output ready);
endinterface

### src/multichannel_trimmed_mean_filter_top.sv
// top level of the multichannel sliding-window trimmed mean filter
// Each input transfer carries a channel number and a signed sample; the sample replaces
// the oldest entry of that channel's circular window of WINDOW values, and one result
// transfer follows with the mean of the window after dropping the TRIM lowest and TRIM
// highest values, truncated toward zero, plus a sticky flag that rises once a shared
// warm-up count of WINDOW-1 window wraps (over all channels) has run out. Windows read as
// zero until written. The block takes one item at a time: the result of an in-range item
// is set by the pairwise ranking of window entries, one pair per cycle through a single
// comparator fed by the two read ports of the window memory, followed by a division by
// the kept count through multiplication with its reciprocal; when 2*TRIM is not below
// WINDOW, the new sample itself is the result. An item on a channel number of CHANNELS
// or more returns zero and changes nothing. The next item is taken while the last result
// still waits; a further result waits until that one has been taken.
`include "multichannel_trimmed_mean_filter_top_macros.svh"

module multichannel_trimmed_mean_filter_top #(
    parameter int CHANNELS     = 8,
    parameter int WINDOW       = 10,
    parameter int TRIM         = 2,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    mctmf_in_if.sink          item,
    mctmf_out_if.source       result
);

    localparam bit KEEP_VALID = (WINDOW > 2 * TRIM);
    localparam int KEEP       = KEEP_VALID ? (WINDOW - 2 * TRIM) : 1;
    localparam int DEPTH      = CHANNELS * WINDOW;
    localparam int AW         = $clog2(DEPTH);
    localparam int PW         = $clog2(WINDOW);
    localparam int CIW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CEW        = CIW + mctmf_pkg::CHANNEL_W;
    localparam int SUM_W      = SAMPLE_WIDTH + PW + 1;

    mctmf_pkg::state_t state_reg;
    mctmf_pkg::state_t state_next;

    // per-channel write position and first-wrap flag
    logic [PW-1:0]                 wp_reg [CHANNELS];
    logic                          wrapped_reg [CHANNELS];
    logic [PW-1:0]                 wraps_left_reg;
    logic                          filled_reg;

    // current item
    logic [CIW-1:0]                ch_idx_reg;
    logic signed [SAMPLE_WIDTH-1:0] smp_reg;
    logic [AW-1:0]                 base_reg;
    logic                          fill_reg;
    logic [PW-1:0]                 lastpos_reg;

    // ranking pass
    logic [PW-1:0]                 i_reg;
    logic [PW-1:0]                 j_reg;
    logic                          p1_valid_reg;
    logic [PW-1:0]                 p1_i_reg;
    logic [PW-1:0]                 p1_j_reg;
    logic [PW-1:0]                 rank_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [SAMPLE_WIDTH-1:0] res_reg;

    // output register
    logic                          out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_filtered_reg;
    logic                          out_filled_reg;

    // control
    logic                          item_ready;
    logic                          accept;
    logic                          mem_we;
    logic                          issue;
    logic                          div_start;
    logic                          out_load;

    logic [CEW-1:0]                ch_ext;
    logic                          ch_in_range;
    logic [CIW-1:0]                ch_idx;
    logic [AW-1:0]                 ch_base;
    logic [PW-1:0]                 wp_cur;
    logic [PW-1:0]                 pos_inc;

    logic [AW-1:0]                 waddr;
    logic [AW-1:0]                 raddr_a;
    logic [AW-1:0]                 raddr_b;
    logic signed [SAMPLE_WIDTH-1:0] rd_a;
    logic signed [SAMPLE_WIDTH-1:0] rd_b;
    logic signed [SAMPLE_WIDTH-1:0] va;
    logic signed [SAMPLE_WIDTH-1:0] vb;
    logic                          b_lt_a;
    logic [PW-1:0]                 rank_cur;
    logic                          keep;
    logic                          last_pair;

    mctmf_pkg::div_status_t        div_st;
    logic signed [SAMPLE_WIDTH-1:0] div_quot;

    // channel decode and window base address
    assign ch_ext      = {CIW'(0), item.channel};
    assign ch_in_range = (ch_ext < CEW'(CHANNELS));
    assign ch_idx      = ch_ext[CIW-1:0];
    assign ch_base     = AW'(ch_idx) * AW'(WINDOW);
    assign accept      = item.valid && item_ready;

    // write position of the current channel
    assign wp_cur  = wp_reg[ch_idx_reg];
    assign pos_inc = (wp_cur == PW'(WINDOW - 1)) ? '0 : (wp_cur + PW'(1));

    // memory addressing
    assign waddr   = base_reg + AW'(wp_cur);
    assign raddr_a = base_reg + AW'(i_reg);
    assign raddr_b = base_reg + AW'(j_reg);

    mctmf_win_ram #(
        .DEPTH (DEPTH),
        .WIDTH (SAMPLE_WIDTH)
    ) u_win_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (waddr),
        .wdata   (smp_reg),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // unwritten entries read as zero
    assign va = (fill_reg || (p1_i_reg <= lastpos_reg)) ? rd_a : '0;
    assign vb = (fill_reg || (p1_j_reg <= lastpos_reg)) ? rd_b : '0;

    // shared comparator, ties broken by position
    assign b_lt_a    = (vb < va) || ((vb == va) && (p1_j_reg < p1_i_reg));
    assign rank_cur  = ((p1_j_reg == '0) ? '0 : rank_reg) + PW'(b_lt_a);
    assign keep      = (int'(rank_cur) >= TRIM) && (int'(rank_cur) < WINDOW - TRIM);
    assign last_pair = (i_reg == PW'(WINDOW - 1)) && (j_reg == PW'(WINDOW - 1));

    mctmf_div #(
        .DIVIDEND_W (SUM_W),
        .QUOT_W     (SAMPLE_WIDTH),
        .DIVISOR    (KEEP)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .status   (div_st),
        .quotient (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mctmf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ch_in_range ? mctmf_pkg::ST_WRITE : mctmf_pkg::ST_DONE;
                end
            end
            mctmf_pkg::ST_WRITE:
            begin
                state_next = mctmf_pkg::ST_RANK;
            end
            mctmf_pkg::ST_RANK:
            begin
                if (last_pair)
                begin
                    state_next = mctmf_pkg::ST_LAST;
                end
            end
            mctmf_pkg::ST_LAST:
            begin
                state_next = KEEP_VALID ? mctmf_pkg::ST_DIVGO : mctmf_pkg::ST_DONE;
            end
            mctmf_pkg::ST_DIVGO:
            begin
                state_next = mctmf_pkg::ST_DIV;
            end
            mctmf_pkg::ST_DIV:
            begin
                if (div_st.done)
                begin
                    state_next = mctmf_pkg::ST_DONE;
                end
            end
            mctmf_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = mctmf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mctmf_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        item_ready = 1'b0;
        mem_we     = 1'b0;
        issue      = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            mctmf_pkg::ST_IDLE:  item_ready = 1'b1;
            mctmf_pkg::ST_WRITE: mem_we     = 1'b1;
            mctmf_pkg::ST_RANK:  issue      = 1'b1;
            mctmf_pkg::ST_DIVGO: div_start  = 1'b1;
            mctmf_pkg::ST_DONE:  out_load   = !out_valid_reg || result.ready;
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mctmf_pkg::ST_IDLE;
            wraps_left_reg <= PW'(WINDOW - 1);
            filled_reg     <= 1'b0;
            p1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                wp_reg[c]      <= '0;
                wrapped_reg[c] <= 1'b0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            p1_valid_reg <= issue;

            // advance write position and warm-up count
            if (mem_we)
            begin
                wp_reg[ch_idx_reg] <= pos_inc;
                if (pos_inc == '0)
                begin
                    wrapped_reg[ch_idx_reg] <= 1'b1;
                    if (wraps_left_reg != '0)
                    begin
                        wraps_left_reg <= wraps_left_reg - PW'(1);
                        if (wraps_left_reg == PW'(1))
                        begin
                            filled_reg <= 1'b1;
                        end
                    end
                end
            end

            // output valid
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        // capture the transfer
        if (accept)
        begin
            ch_idx_reg <= ch_idx;
            smp_reg    <= item.sample;
            base_reg   <= ch_base;
            res_reg    <= '0;
        end

        // valid extent of the window after the write
        if (mem_we)
        begin
            fill_reg    <= wrapped_reg[ch_idx_reg] || (pos_inc == '0);
            lastpos_reg <= wp_cur;
            i_reg       <= '0;
            j_reg       <= '0;
            sum_reg     <= '0;
        end

        // pair counters
        if (issue)
        begin
            p1_i_reg <= i_reg;
            p1_j_reg <= j_reg;
            if (j_reg == PW'(WINDOW - 1))
            begin
                j_reg <= '0;
                i_reg <= i_reg + PW'(1);
            end
            else
            begin
                j_reg <= j_reg + PW'(1);
            end
        end

        // rank count and sum of kept entries
        if (p1_valid_reg)
        begin
            rank_reg <= rank_cur;
            if ((p1_j_reg == PW'(WINDOW - 1)) && keep)
            begin
                sum_reg <= sum_reg + SUM_W'(va);
            end
        end

        // result selection
        if ((state_reg == mctmf_pkg::ST_LAST) && !KEEP_VALID)
        begin
            res_reg <= smp_reg;
        end
        if ((state_reg == mctmf_pkg::ST_DIV) && div_st.done)
        begin
            res_reg <= div_quot;
        end

        // output payload
        if (out_load)
        begin
            out_filtered_reg <= res_reg;
            out_filled_reg   <= filled_reg;
        end
    end

    assign item.ready           = item_ready;
    assign result.valid         = out_valid_reg;
    assign result.filtered      = out_filtered_reg;
    assign result.buffer_filled = out_filled_reg;

    // checks
    `MCTMF_ASSERT_NEXT(a_accept_moves_on, accept, (state_reg == mctmf_pkg::ST_WRITE) || (state_reg == mctmf_pkg::ST_DONE))
    `MCTMF_ASSERT_NOW(a_filled_matches_count, 1'b1, filled_reg == (wraps_left_reg == '0))
    `MCTMF_ASSERT_NOW(a_div_start_idle, div_start, !div_st.busy)
    `MCTMF_ASSERT_NOW(a_write_no_read_pending, mem_we, !p1_valid_reg)
    `MCTMF_ASSERT_NOW(a_last_pair_in_flight, state_reg == mctmf_pkg::ST_LAST, p1_valid_reg && (p1_i_reg == PW'(WINDOW - 1)) && (p1_j_reg == PW'(WINDOW - 1)))

endmodule

### src/mctmf_win_ram.sv
// window sample memory, one write port and two registered read ports
module mctmf_win_ram #(
    parameter int DEPTH = 80,
    parameter int WIDTH = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and both reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### src/mctmf_div.sv
// divider by a fixed divisor through reciprocal multiplication, truncating toward zero
module mctmf_div #(
    parameter int DIVIDEND_W = 29,
    parameter int QUOT_W     = 24,
    parameter int DIVISOR    = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [DIVIDEND_W-1:0]  dividend,
    output mctmf_pkg::div_status_t        status,
    output logic signed [QUOT_W-1:0]      quotient
);

    // floor(x / DIVISOR) equals floor(x * RECIP / 2**SHIFT) for every x below 2**DIVIDEND_W
    localparam int DSH   = $clog2(DIVISOR);
    localparam int SHIFT = DIVIDEND_W + DSH;
    localparam int RW    = DIVIDEND_W + 1;
    localparam int PRW   = DIVIDEND_W + RW;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_FULL);

    logic                  busy_reg;
    logic                  done_reg;
    logic                  neg_reg;
    logic [DIVIDEND_W-1:0] mag_reg;
    logic [PRW-1:0]        prod_reg;

    logic [DIVIDEND_W-1:0] dvd_u;
    logic [DIVIDEND_W-1:0] dvd_abs;
    logic [QUOT_W-1:0]     q_mag;

    // magnitude of the dividend
    assign dvd_u   = dividend;
    assign dvd_abs = dvd_u[DIVIDEND_W-1] ? (~dvd_u + DIVIDEND_W'(1)) : dvd_u;

    // step control: magnitude captured, then product, then quotient ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    // magnitude and reciprocal product
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= dvd_abs;
            neg_reg <= dvd_u[DIVIDEND_W-1];
        end
        if (busy_reg)
        begin
            prod_reg <= PRW'(mag_reg) * PRW'(RECIP);
        end
    end

    // restore the sign
    assign q_mag       = prod_reg[SHIFT +: QUOT_W];
    assign quotient    = neg_reg ? (~q_mag + QUOT_W'(1)) : q_mag;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
